/* rtl/nfa_pkg.sv */
package nfa_pkg;

   localparam int WORD_W = 8;
   localparam int BIT_W  = 3;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [5:0] release_id;
   } nfa_req_type;

   typedef struct packed {
      logic [5:0] granted_id;
      logic       pool_full;
   } nfa_rsp_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] bit_idx;
   } nfa_find_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FREE,
      ST_SCAN
   } nfa_state_type;

endpackage

/* rtl/nfa_map_ram.sv */
module nfa_map_ram #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [nfa_pkg::WORD_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [nfa_pkg::WORD_W-1:0] wr_data
);
   import nfa_pkg::*;

   logic [WORD_W-1:0] map_mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/nfa_word_find.sv */
module nfa_word_find #(
   parameter int POOL_SIZE = 64
) (
   input  logic [nfa_pkg::WORD_W-1:0] map_word,
   input  logic [nfa_pkg::BIT_W-1:0]  start_bit,
   input  logic                       first_look,
   input  logic                       wrap_look,
   input  logic                       last_word,
   output nfa_pkg::nfa_find_type      find_result
);
   import nfa_pkg::*;

   localparam int NUM_WORDS = (POOL_SIZE + WORD_W - 1) / WORD_W;
   localparam int LAST_BITS = POOL_SIZE - WORD_W * (NUM_WORDS - 1);
   localparam logic [WORD_W-1:0] LAST_MASK = WORD_W'((1 << LAST_BITS) - 1);

   logic [WORD_W-1:0] upper_mask;
   logic [WORD_W-1:0] window;
   logic [WORD_W-1:0] free_bits;

   always_comb begin
      upper_mask = {WORD_W{1'b1}} << start_bit;
      // The first word looks at or above the hint; the wrapped revisit of
      // the same word looks only below it.
      if (first_look) begin
         window = upper_mask;
      end else if (wrap_look) begin
         window = ~upper_mask;
      end else begin
         window = {WORD_W{1'b1}};
      end
      if (last_word) begin
         window = window & LAST_MASK;
      end
      free_bits = ~map_word & window;
      find_result.found   = |free_bits;
      find_result.bit_idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            find_result.bit_idx = BIT_W'(i);
         end
      end
   end

endmodule

/* rtl/next_fit_id_allocator.sv */
// Next-fit identifier allocator over a pool of POOL_SIZE identifiers.
// Input channel: a word (cmd, release_id) is taken at a rising edge where
// start is high and busy is low. Allocate returns one result word; free and
// clear return none. Results appear on rsp_word for exactly one cycle,
// flagged by rsp_valid; the receiver cannot stall them.
// The used bits live in a synchronous memory of 8-bit words, one word read
// per cycle. Allocate scans from the word holding the search hint, wraps once
// to word zero and ends back at the hint word; the result is registered as
// soon as a word shows a free bit, or after the hint word is checked again
// when the pool is full. Free of an identifier below POOL_SIZE is a
// read-modify-write of one word and keeps busy high for one cycle. Clear and
// reset sweep the memory to zero, one word per cycle, so busy stays high
// until all NUM_WORDS (ceil(POOL_SIZE / 8)) words are written. The scan loop
// over memory words sets the allocate latency.
module next_fit_id_allocator #(
   parameter int POOL_SIZE = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  nfa_pkg::nfa_req_type req_word,
   output logic                 rsp_valid,
   output nfa_pkg::nfa_rsp_type rsp_word
);
   import nfa_pkg::*;

   localparam int NUM_WORDS = (POOL_SIZE + WORD_W - 1) / WORD_W;
   localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int ID_W      = ADDR_W + BIT_W;
   localparam int CNT_W     = $clog2(NUM_WORDS + 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_WORDS - 1);
   localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(NUM_WORDS);
   localparam logic [ID_W-1:0]   LAST_ID   = ID_W'(POOL_SIZE - 1);

   nfa_state_type state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ID_W-1:0]   hint_ff, hint_in;
   logic [ID_W-1:0]   slot_ff, slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   nfa_rsp_type       rsp_word_ff, rsp_word_in;

   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;

   nfa_find_type      find_result;
   logic [ADDR_W-1:0] next_addr;
   logic [ID_W-1:0]   found_slot;
   logic [ID_W-1:0]   rid_id;
   logic              rid_in_range;

   nfa_map_ram #(
      .DEPTH  (NUM_WORDS),
      .ADDR_W (ADDR_W)
   ) u_map_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   nfa_word_find #(
      .POOL_SIZE (POOL_SIZE)
   ) u_word_find (
      .map_word    (rd_data),
      .start_bit   (hint_ff[BIT_W-1:0]),
      .first_look  (cnt_ff == '0),
      .wrap_look   (cnt_ff == LAST_CNT),
      .last_word   (addr_ff == LAST_ADDR),
      .find_result (find_result)
   );

   assign next_addr    = (addr_ff == LAST_ADDR) ? '0 : addr_ff + 1'b1;
   assign found_slot   = {addr_ff, find_result.bit_idx};
   assign rid_id       = ID_W'(req_word.release_id);
   assign rid_in_range = 32'(req_word.release_id) < 32'(POOL_SIZE);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      hint_in      = hint_ff;
      slot_in      = slot_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      rd_en        = 1'b0;
      rd_addr      = addr_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            addr_in = next_addr;
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               unique case (req_word.cmd)
                  CMD_ALLOC: begin
                     rd_en    = 1'b1;
                     rd_addr  = hint_ff[ID_W-1:BIT_W];
                     addr_in  = hint_ff[ID_W-1:BIT_W];
                     cnt_in   = '0;
                     state_in = ST_SCAN;
                  end
                  CMD_FREE: begin
                     if (rid_in_range) begin
                        rd_en    = 1'b1;
                        rd_addr  = rid_id[ID_W-1:BIT_W];
                        slot_in  = rid_id;
                        state_in = ST_FREE;
                     end
                  end
                  CMD_CLEAR: begin
                     addr_in  = '0;
                     hint_in  = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FREE: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff[ID_W-1:BIT_W];
            wr_data  = rd_data & ~(WORD_W'(1) << slot_ff[BIT_W-1:0]);
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            // Read the next word while the current one is checked.
            rd_en   = (cnt_ff != LAST_CNT);
            rd_addr = next_addr;
            addr_in = next_addr;
            cnt_in  = cnt_ff + 1'b1;
            if (find_result.found) begin
               wr_en                  = 1'b1;
               wr_addr                = addr_ff;
               wr_data                = rd_data | (WORD_W'(1) << find_result.bit_idx);
               hint_in                = (found_slot == LAST_ID) ? '0 : found_slot + 1'b1;
               rsp_valid_in           = 1'b1;
               rsp_word_in.granted_id = 6'(found_slot);
               rsp_word_in.pool_full  = 1'b0;
               state_in               = ST_IDLE;
            end else if (cnt_ff == LAST_CNT) begin
               hint_in                = '0;
               rsp_valid_in           = 1'b1;
               rsp_word_in.granted_id = '0;
               rsp_word_in.pool_full  = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      slot_ff     <= slot_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* sim/next_fit_id_allocator_tb.sv */
`timescale 1ns / 1ps

module next_fit_id_allocator_tb;
   import nfa_pkg::*;

   localparam int POOL_SIZE   = 64;
   localparam int NUM_WORDS   = (POOL_SIZE + WORD_W - 1) / WORD_W;
   localparam int SETTLE_CYC  = NUM_WORDS + 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_GAP     = 40;

   // The only command code the block leaves unused.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   nfa_req_type req_word;
   logic        rsp_valid;
   nfa_rsp_type rsp_word;

   // Predicted state of the pool.
   bit [POOL_SIZE-1:0] used_bits;
   int unsigned        search_hint;
   nfa_rsp_type        pending_grants[$];

   int error_count;
   int alloc_count;
   int full_count;
   int free_count;
   int clear_count;
   int ignored_count;

   next_fit_id_allocator #(
      .POOL_SIZE(POOL_SIZE)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_word (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("next_fit_id_allocator_tb NOT OK");
      $finish;
   end

   // Updates the predicted pool for one accepted word and queues the grant
   // that an allocate is due to return.
   task automatic predict_request(input nfa_req_type w);
      nfa_rsp_type grant;
      int          slot;
      begin
         slot = -1;
         case (w.cmd)
            CMD_ALLOC: begin
               if (search_hint >= POOL_SIZE) search_hint = 0;
               for (int i = search_hint; i < POOL_SIZE; i++) begin
                  if (slot < 0 && !used_bits[i]) slot = i;
               end
               if (slot < 0) begin
                  search_hint = 0;
                  for (int i = 0; i < POOL_SIZE; i++) begin
                     if (slot < 0 && !used_bits[i]) slot = i;
                  end
               end
               if (slot >= 0) begin
                  used_bits[slot] = 1'b1;
                  search_hint = (slot + 1) % POOL_SIZE;
                  grant.granted_id = slot[5:0];
                  grant.pool_full  = 1'b0;
               end else begin
                  grant.granted_id = '0;
                  grant.pool_full  = 1'b1;
                  full_count++;
               end
               pending_grants.push_back(grant);
               alloc_count++;
            end
            CMD_FREE: begin
               if (w.release_id < POOL_SIZE) used_bits[w.release_id] = 1'b0;
               free_count++;
            end
            CMD_CLEAR: begin
               used_bits   = '0;
               search_hint = 0;
               clear_count++;
            end
            default: ignored_count++;
         endcase
      end
   endtask

   // Holds start low for the idle gap when gap is above zero, then offers the word until the block
   // takes it. Start is left high so back-to-back words need no toggle.
   task automatic send_word(input logic [1:0] cmd, input logic [5:0] id, input int gap);
      nfa_req_type w;
      begin
         w.cmd        = cmd;
         w.release_id = id;
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_word <= w;
         start    <= 1'b1;
         do @(posedge clock); while (busy);
         predict_request(w);
      end
   endtask

   task automatic wait_drained();
      begin
         start <= 1'b0;
         do @(posedge clock); while (pending_grants.size() != 0);
         repeat (SETTLE_CYC) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_grants.size() == 0) begin
            $error("unexpected result word: granted_id %0d pool_full %0b",
                   rsp_word.granted_id, rsp_word.pool_full);
            error_count++;
         end else begin
            if (rsp_word.granted_id !== pending_grants[0].granted_id) begin
               $error("granted_id: expected %0d, actual %0d",
                      pending_grants[0].granted_id, rsp_word.granted_id);
               error_count++;
            end
            if (rsp_word.pool_full !== pending_grants[0].pool_full) begin
               $error("pool_full: expected %0b, actual %0b",
                      pending_grants[0].pool_full, rsp_word.pool_full);
               error_count++;
            end
            void'(pending_grants.pop_front());
         end
      end
   end

   task automatic test_basic_commands();
      begin
         send_word(CMD_ALLOC, 6'd63, 0);
         send_word(CMD_ALLOC, 6'd0, 0);
         send_word(CMD_ALLOC, 6'h2a, 0);
         send_word(CMD_FREE, 6'd1, 0);
         // The hole at 1 is skipped: the search resumes after the last grant.
         send_word(CMD_ALLOC, 6'h15, 1);
         send_word(CMD_FREE, 6'd63, 0);
         send_word(CMD_FREE, 6'd0, 0);
         send_word(CMD_FREE, 6'd0, 2);
         send_word(CMD_UNUSED, 6'd63, 0);
         send_word(CMD_UNUSED, 6'd0, 0);
         send_word(CMD_ALLOC, 6'd0, 0);
         send_word(CMD_CLEAR, 6'd63, 0);
         send_word(CMD_ALLOC, 6'd0, 0);
         send_word(CMD_ALLOC, 6'd0, 3);
         send_word(CMD_CLEAR, 6'd0, 0);
         send_word(CMD_FREE, 6'd5, 0);
         send_word(CMD_ALLOC, 6'd63, 0);
         wait_drained();
      end
   endtask

   task automatic test_pool_full();
      begin
         send_word(CMD_CLEAR, 6'd0, 0);
         for (int i = 0; i < POOL_SIZE - 1; i++) send_word(CMD_ALLOC, i[5:0], 0);
         send_word(CMD_FREE, 6'd5, 0);
         // The hint sits on the last identifier, then wraps to the hole.
         send_word(CMD_ALLOC, 6'd0, 0);
         send_word(CMD_ALLOC, 6'd0, 0);
         send_word(CMD_ALLOC, 6'd0, 0);
         send_word(CMD_ALLOC, 6'd63, 2);
         send_word(CMD_FREE, 6'd0, 0);
         send_word(CMD_FREE, 6'd63, 0);
         send_word(CMD_ALLOC, 6'd0, 0);
         send_word(CMD_ALLOC, 6'd0, 0);
         send_word(CMD_ALLOC, 6'd0, 0);
         send_word(CMD_CLEAR, 6'd0, 0);
         wait_drained();
      end
   endtask

   // Random traffic. Most frees release an identifier that is in use, so the
   // pool keeps a realistic mix of holes; clears are rare so it can fill up.
   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int alloc_pct);
      logic [1:0] cmd;
      logic [5:0] id;
      int         pick;
      int         gap;
      int         probe;
      begin
         for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            id   = 6'($urandom);
            if (pick < alloc_pct) begin
               cmd = CMD_ALLOC;
            end else if (pick < 96) begin
               cmd = CMD_FREE;
               if ($urandom_range(4) != 0) begin
                  probe = $urandom_range(POOL_SIZE - 1);
                  for (int k = 0; k < POOL_SIZE; k++) begin
                     if (used_bits[(probe + k) % POOL_SIZE]) begin
                        id    = 6'((probe + k) % POOL_SIZE);
                        k     = POOL_SIZE;
                     end
                  end
               end
            end else if (pick < 98) begin
               cmd = CMD_CLEAR;
            end else begin
               cmd = CMD_UNUSED;
            end
            gap = 0;
            while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
            send_word(cmd, id, gap);
            if (n == count / 2 && $urandom_range(1) == 1) wait_drained();
         end
         wait_drained();
      end
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_word      = '0;
      used_bits     = '0;
      search_hint   = 0;
      error_count   = 0;
      alloc_count   = 0;
      full_count    = 0;
      free_count    = 0;
      clear_count   = 0;
      ignored_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_basic_commands();
      test_pool_full();
      test_random_traffic(150, 0, 55);
      test_random_traffic(150, 75, 75);
      test_random_traffic(150, 32, 45);
      test_random_traffic(150, 0, 85);

      wait_drained();
      if (pending_grants.size() != 0) begin
         $error("%0d expected result words never arrived", pending_grants.size());
         error_count++;
      end
      $display("Covered %0d allocates (%0d on a full pool), %0d frees, %0d clears,",
               alloc_count, full_count, free_count, clear_count);
      $display("and %0d unused-command words, with and without sender idle gaps.",
               ignored_count);
      if (error_count == 0) begin
         $display("next_fit_id_allocator_tb OK");
      end else begin
         $display("next_fit_id_allocator_tb NOT OK");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/nfa_pkg.sv
rtl/nfa_map_ram.sv
rtl/nfa_word_find.sv
rtl/next_fit_id_allocator.sv
sim/next_fit_id_allocator_tb.sv
